FILE: rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the sextet frame receiver: line byte classes,
// register indexes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Line byte and field widths.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned SextetW   = 6;
  localparam int unsigned PosW      = 6;
  localparam int unsigned GroupW    = 4;
  localparam int unsigned IdW       = 16;
  localparam int unsigned OutDataW  = 24;
  localparam int unsigned CfgIndexW = 2;

  // At most fifteen groups of four sextets, i.e. 45 bytes, are decoded.
  localparam logic [GroupW-1:0] MaxGroups = 4'd15;

  // Reset value of the acknowledged head code register.
  localparam logic [ByteW-1:0] AckedHeadReset = 8'd130;

  // Register indexes of the configuration channel.
  typedef enum logic [CfgIndexW-1:0] {
    CfgOwnAddrHigh = 2'd0,
    CfgOwnAddrLow  = 2'd1,
    CfgAckedHead   = 2'd2
  } cfg_index_e;

  // Controller states, one-hot.
  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StHdrRead = 7'b0000010,
    StHdrCap  = 7'b0000100,
    StCheck   = 7'b0001000,
    StEmRead  = 7'b0010000,
    StEmCap   = 7'b0100000,
    StOut     = 7'b1000000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_fire;   // line byte transaction this cycle
    logic cap;       // capture the sextet read in the previous cycle
    logic hdr;       // capture is part of the header pass
    logic check;     // apply address and duplicate filters
    logic out_step;  // result transaction this cycle
  } sfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tail_go;    // current line byte is a tail that closes a decodable frame
    logic grp_end;    // this capture completes a group of four sextets
    logic hdr_end;    // the completed group is the last one the header needs
    logic keep;       // frame passes the filters
    logic byte3;      // third byte of the current group is on the output
    logic frame_end;  // final byte of the frame is on the output
  } sfr_stat_t;

  // Line byte classes.
  function automatic logic is_head(input logic [ByteW-1:0] b);
    return b[7];
  endfunction

  function automatic logic is_sextet(input logic [ByteW-1:0] b);
    return (b[7:6] == 2'b00);
  endfunction

  function automatic logic is_tail(input logic [ByteW-1:0] b);
    return (b[7:6] == 2'b01);
  endfunction

endpackage

FILE: rtl/core/sextet_frame_receiver.sv
// ----------------------------------------------------------------------------
// sextet_frame_receiver
// Assembles framed sextet streams into decoded bytes and emits frames that
// pass the address and duplicate filters.
// ----------------------------------------------------------------------------
// Line bytes enter on the s_axis channel, one per transaction: a head opens a
// frame, sextets are stored, a tail closes it. Each decoded byte of an
// accepted frame leaves on the m_axis channel with the head byte in tuser and
// tlast on the final byte. The cfg channel is always ready; the user must write it only
// while no frame is in flight, and the block itself does not enforce this.
// Heads, sextets and tails that decode fewer than two groups are taken without a stall.
// A tail with G >= 2 groups holds s_axis_tready low through the reading of the
// header groups (two, or three when G >= 3), one check state, and, for a kept
// frame, the reading of each group followed by its 3 output transactions. Each
// sextet passes through a read state and a capture state of the registered store.
// A stalled m_axis_tready extends the output phase cycle by cycle.
// Reset closes any open frame, clears the last command id and loads the
// register defaults; the sextet store is not cleared.
// ----------------------------------------------------------------------------
module sextet_frame_receiver
  import sfr_pkg::*;
#(
  parameter int unsigned SEXTET_CAPACITY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Line bytes.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
  // Decoded bytes.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // [7:0] decoded_byte,
                                               // [13:8] byte_position,
                                               // [21:14] declared_length
  output logic [7:0]           m_axis_tuser,   // [7:0] frame_head
  output logic                 m_axis_tlast,
  // Configuration writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]     cfg_data_i
);

  sfr_cmd_t         cmd;
  sfr_stat_t        stat;
  logic [ByteW-1:0] frame_head;
  logic [ByteW-1:0] decoded_byte;
  logic [PosW-1:0]  byte_position;
  logic [ByteW-1:0] declared_length;
  logic             last_byte;

  // Controller.
  sfr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Datapath.
  sfr_datapath #(
    .SEXTET_CAPACITY (SEXTET_CAPACITY)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .rx_byte_i         (s_axis_tdata),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .frame_head_o      (frame_head),
    .decoded_byte_o    (decoded_byte),
    .byte_position_o   (byte_position),
    .declared_length_o (declared_length),
    .last_byte_o       (last_byte)
  );

  // Output packing.
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tdata  = {2'b00, declared_length, byte_position, decoded_byte};
  assign m_axis_tuser  = frame_head;
  assign m_axis_tlast  = last_byte;

endmodule

FILE: rtl/core/sfr_ram.sv
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sfr_ram #(
  parameter int unsigned DataWidth = 6,
  parameter int unsigned Depth     = 63
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataWidth-1:0]     wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataWidth-1:0]     rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sfr_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_ctrl
// Controller of the sextet frame receiver. Sequences the header pass, the
// filter check and the byte-by-byte emission of an accepted frame.
// ----------------------------------------------------------------------------
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  input  sfr_stat_t stat_i,
  output sfr_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (s_valid_i && stat_i.tail_go) state_d = StHdrRead;
      end
      StHdrRead: state_d = StHdrCap;
      StHdrCap: begin
        if (stat_i.grp_end && stat_i.hdr_end) state_d = StCheck;
        else                                  state_d = StHdrRead;
      end
      StCheck: begin
        state_d = stat_i.keep ? StEmRead : StIdle;
      end
      StEmRead: state_d = StEmCap;
      StEmCap: begin
        state_d = stat_i.grp_end ? StOut : StEmRead;
      end
      StOut: begin
        if (m_ready_i && stat_i.byte3) begin
          state_d = stat_i.frame_end ? StIdle : StEmRead;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Handshakes and datapath commands.
  assign s_ready_o = (state_q == StIdle);
  assign m_valid_o = (state_q == StOut);

  always_comb begin
    cmd_o          = '0;
    cmd_o.in_fire  = (state_q == StIdle) && s_valid_i;
    cmd_o.cap      = (state_q == StHdrCap) || (state_q == StEmCap);
    cmd_o.hdr      = (state_q == StHdrCap);
    cmd_o.check    = (state_q == StCheck);
    cmd_o.out_step = (state_q == StOut) && m_ready_i;
  end

endmodule

FILE: rtl/core/sfr_datapath.sv
// ----------------------------------------------------------------------------
// sfr_datapath
// Datapath of the sextet frame receiver: frame position, sextet store,
// group assembly, header bytes, filters, configuration and result fields.
// ----------------------------------------------------------------------------
module sfr_datapath
  import sfr_pkg::*;
#(
  parameter int unsigned SEXTET_CAPACITY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfr_cmd_t             cmd_i,
  output sfr_stat_t            stat_o,
  input  logic [ByteW-1:0]     rx_byte_i,
  input  logic                 cfg_valid_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]     cfg_data_i,
  output logic [ByteW-1:0]     frame_head_o,
  output logic [ByteW-1:0]     decoded_byte_o,
  output logic [PosW-1:0]      byte_position_o,
  output logic [ByteW-1:0]     declared_length_o,
  output logic                 last_byte_o
);

  localparam int unsigned Depth = SEXTET_CAPACITY - 1;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned FposW = $clog2(SEXTET_CAPACITY + 1);
  localparam logic [FposW-1:0] FposFull = FposW'(SEXTET_CAPACITY);

  // Configuration registers.
  logic [ByteW-1:0] own_hi_q, own_lo_q, acked_q;

  // Frame state.
  logic [FposW-1:0]  fpos_q, fpos_d;
  logic [ByteW-1:0]  head_q;
  logic [IdW-1:0]    last_id_q;
  logic [GroupW-1:0] groups_q;
  logic [PosW-1:0]   nbytes_q;

  // Sequencing counters.
  logic [GroupW-1:0] grp_idx_q;
  logic [1:0]        sub_q;
  logic [PosW-1:0]   out_pos_q;
  logic [1:0]        out_sel_q;

  // Assembly and header bytes.
  logic [23:0]      grp_q;
  logic [23:0]      grp_new;
  logic [ByteW-1:0] b0_q, b1_q, b4_q, b5_q, b7_q;

  // Store access.
  logic               st_we;
  logic [AddrW-1:0]   st_waddr;
  logic [AddrW-1:0]   st_raddr;
  logic [SextetW-1:0] st_rdata;

  // Tail decoding.
  logic [FposW-1:0]  nsext_quads;
  logic [GroupW-1:0] groups_new;
  logic              fpos_open;
  logic              addr_ok;
  logic              is_dup;
  logic              acked_frame;
  logic [IdW-1:0]    frame_id;

  assign fpos_open   = (fpos_q != '0);
  assign nsext_quads = (fpos_q - FposW'(1)) >> 2;
  assign groups_new  = (nsext_quads > FposW'(MaxGroups)) ? MaxGroups
                                                          : GroupW'(nsext_quads);

  // Sextet store.
  assign st_we    = cmd_i.in_fire && is_sextet(rx_byte_i) && fpos_open &&
                    (fpos_q < FposFull);
  assign st_waddr = AddrW'(fpos_q - FposW'(1));
  assign st_raddr = AddrW'({grp_idx_q, sub_q});

  sfr_ram #(
    .DataWidth (SextetW),
    .Depth     (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (rx_byte_i[SextetW-1:0]),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Configuration writes; an index beyond the register list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_hi_q <= '0;
      own_lo_q <= '0;
      acked_q  <= AckedHeadReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgOwnAddrHigh: own_hi_q <= cfg_data_i;
        CfgOwnAddrLow:  own_lo_q <= cfg_data_i;
        CfgAckedHead:   acked_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame position: heads open, sextets count, overflow and tails close.
  always_comb begin
    fpos_d = fpos_q;
    if (cmd_i.in_fire) begin
      if (is_head(rx_byte_i)) begin
        fpos_d = FposW'(1);
      end else if (is_sextet(rx_byte_i)) begin
        if (fpos_q >= FposFull) fpos_d = '0;
        else if (fpos_open)     fpos_d = fpos_q + FposW'(1);
      end else begin
        fpos_d = '0;
      end
    end
  end

  // Filters on the header bytes.
  assign frame_id    = {b0_q, b1_q};
  assign addr_ok     = ((b4_q == '0) && (b5_q == '0)) ||
                       ((b4_q == own_hi_q) && (b5_q == own_lo_q));
  assign acked_frame = (head_q == acked_q);
  assign is_dup      = acked_frame && (frame_id != '0) && (frame_id == last_id_q);

  // Control registers of the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpos_q    <= '0;
      head_q    <= '0;
      last_id_q <= '0;
      groups_q  <= '0;
      nbytes_q  <= '0;
      grp_idx_q <= '0;
      sub_q     <= '0;
      out_pos_q <= '0;
      out_sel_q <= '0;
    end else begin
      fpos_q <= fpos_d;
      if (cmd_i.in_fire && is_head(rx_byte_i)) begin
        head_q <= rx_byte_i;
      end
      if (cmd_i.in_fire && is_tail(rx_byte_i) && fpos_open) begin
        groups_q  <= groups_new;
        nbytes_q  <= PosW'({groups_new, 1'b0}) + PosW'(groups_new);
        grp_idx_q <= '0;
        sub_q     <= '0;
      end
      if (cmd_i.cap) begin
        sub_q <= sub_q + 2'd1;
        if (sub_q == 2'd3) grp_idx_q <= grp_idx_q + GroupW'(1);
      end
      if (cmd_i.check) begin
        grp_idx_q <= '0;
        sub_q     <= '0;
        out_pos_q <= '0;
        out_sel_q <= '0;
        if (addr_ok && acked_frame && !is_dup) last_id_q <= frame_id;
      end
      if (cmd_i.out_step) begin
        out_pos_q <= out_pos_q + PosW'(1);
        out_sel_q <= (out_sel_q == 2'd2) ? 2'd0 : out_sel_q + 2'd1;
      end
    end
  end

  // Group assembly, most significant sextet first.
  assign grp_new = {grp_q[17:0], st_rdata};

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      grp_q <= grp_new;
    end
    if (cmd_i.hdr && (sub_q == 2'd3)) begin
      unique case (grp_idx_q)
        GroupW'(0): begin
          b0_q <= grp_new[23:16];
          b1_q <= grp_new[15:8];
        end
        GroupW'(1): begin
          b4_q <= grp_new[15:8];
          b5_q <= grp_new[7:0];
        end
        GroupW'(2): b7_q <= grp_new[15:8];
        default: ;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o           = '0;
    stat_o.tail_go   = is_tail(rx_byte_i) && fpos_open && (groups_new >= GroupW'(2));
    stat_o.grp_end   = (sub_q == 2'd3);
    stat_o.hdr_end   = (grp_idx_q == ((groups_q >= GroupW'(3)) ? GroupW'(2) : GroupW'(1)));
    stat_o.keep      = addr_ok && !is_dup;
    stat_o.byte3     = (out_sel_q == 2'd2);
    stat_o.frame_end = (out_pos_q == nbytes_q - PosW'(1));
  end

  // Result fields.
  always_comb begin
    unique case (out_sel_q)
      2'd0:    decoded_byte_o = grp_q[23:16];
      2'd1:    decoded_byte_o = grp_q[15:8];
      default: decoded_byte_o = grp_q[7:0];
    endcase
  end

  assign frame_head_o      = head_q;
  assign byte_position_o   = out_pos_q;
  assign declared_length_o = (groups_q >= GroupW'(3)) ? b7_q : '0;
  assign last_byte_o       = stat_o.frame_end;

endmodule

FILE: rtl/core/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_port_checks
// Port-level checks of the sextet frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [7:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Line bytes are never taken while a decoded byte is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output valid");

  // A stalled decoded byte holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled output changed");

  // The final byte of a frame returns the receiver to taking line bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("receiver not ready after frame end");

  // Within a frame the receiver stays busy between decoded bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
    else $error("receiver took input in the middle of a frame");

endmodule

bind sextet_frame_receiver sfr_port_checks u_sfr_port_checks (.*);

FILE: bench/sfr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfr_checker
// Watches the line byte, decoded byte and configuration channels of the
// sextet frame receiver. It keeps its own model of the frame assembly and
// filters, queues the decoded bytes every frame should produce, and compares
// each decoded byte transaction against the oldest queued byte.
// ----------------------------------------------------------------------------
module sfr_checker
  import sfr_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Line byte channel.
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,
  // Decoded byte channel.
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [23:0]          m_axis_tdata,
  input  logic [7:0]           m_axis_tuser,
  input  logic                 m_axis_tlast,
  // Configuration channel.
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  // Results for the testbench top.
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          frames_o,
  output int unsigned          bytes_o
);

  localparam int unsigned MaxGroups  = 15;
  localparam int unsigned ReportMax  = 10;

  // One decoded byte as it should appear on the output channel.
  typedef struct packed {
    logic [7:0] head;
    logic [7:0] value;
    logic [5:0] position;
    logic [7:0] length;
    logic       last;
  } decoded_byte_t;

  decoded_byte_t owed_bytes[$];

  // Register copies.
  logic [7:0] addr_high;
  logic [7:0] addr_low;
  logic [7:0] acked_head;

  // Frame assembly state: open_pos is zero with no open frame, otherwise one
  // more than the number of stored sextets.
  int unsigned open_pos;
  logic [7:0]  open_head;
  logic [5:0]  sextets [0:CAPACITY-1];
  logic [15:0] last_id;

  // Set once the line byte on offer has been modeled; cleared by its
  // transaction. The source holds the byte stable while it waits, so the
  // byte can be modeled the first cycle it is offered, which keeps the
  // expectations ahead of results that leave before a tail is taken.
  logic offer_modeled;

  // Model one line byte and queue the decoded bytes of a frame it releases.
  task automatic decode_line_byte(input logic [7:0] b);
    logic [7:0]    dec [0:44];
    logic [23:0]   word;
    logic [15:0]   id;
    logic [7:0]    len;
    logic          keep;
    int unsigned   ngroups;
    int unsigned   nbytes;
    int unsigned   g;
    int unsigned   k;
    decoded_byte_t item;
    if (b[7:6] == 2'b00) begin
      // Payload sextet: a full store aborts the frame.
      if (open_pos >= CAPACITY) begin
        open_pos = 0;
      end else if (open_pos > 0) begin
        sextets[(open_pos - 1) % CAPACITY] = b[5:0];
        open_pos++;
      end
    end else if (b[7]) begin
      // Head byte: a frame still open is simply replaced.
      open_head = b;
      open_pos  = 1;
    end else if (open_pos != 0) begin
      // Tail byte closing an open frame.
      ngroups  = (open_pos - 1) / 4;
      open_pos = 0;
      if (ngroups > MaxGroups) ngroups = MaxGroups;
      nbytes = ngroups * 3;
      if (nbytes >= 6) begin
        for (g = 0; g < ngroups; g++) begin
          word = {sextets[(4 * g) % CAPACITY], sextets[(4 * g + 1) % CAPACITY],
                  sextets[(4 * g + 2) % CAPACITY], sextets[(4 * g + 3) % CAPACITY]};
          dec[3 * g]     = word[23:16];
          dec[3 * g + 1] = word[15:8];
          dec[3 * g + 2] = word[7:0];
        end
        // Destination must be this node or broadcast.
        keep = ((dec[4] == 8'h00) && (dec[5] == 8'h00)) ||
               ((dec[4] == addr_high) && (dec[5] == addr_low));
        // Acknowledged frames repeating a nonzero id are duplicates.
        if (keep && (open_head == acked_head)) begin
          id = {dec[0], dec[1]};
          if ((id != 16'h0000) && (id == last_id)) keep = 1'b0;
          else last_id = id;
        end
        if (keep) begin
          len = (nbytes >= 8) ? dec[7] : 8'h00;
          for (k = 0; k < nbytes; k++) begin
            item.head     = open_head;
            item.value    = dec[k];
            item.position = k[5:0];
            item.length   = len;
            item.last     = (k + 1 == nbytes);
            owed_bytes.push_back(item);
          end
          frames_o++;
        end
      end
    end
  endtask

  // Compare one decoded byte transaction with the oldest owed byte.
  task automatic check_decoded_byte();
    decoded_byte_t want;
    decoded_byte_t got;
    got.head     = m_axis_tuser;
    got.value    = m_axis_tdata[7:0];
    got.position = m_axis_tdata[13:8];
    got.length   = m_axis_tdata[21:14];
    got.last     = m_axis_tlast;
    bytes_o++;
    if (owed_bytes.size() == 0) begin
      if (fail_count_o < ReportMax)
        $display("%0t: unexpected decoded byte: head %02h byte %02h pos %0d len %02h last %0b",
                 $time, got.head, got.value, got.position, got.length, got.last);
      fail_count_o++;
    end else begin
      want = owed_bytes.pop_front();
      if (got != want) begin
        if (fail_count_o < ReportMax) begin
          $display("%0t: decoded byte mismatch", $time);
          $display("  expected head %02h byte %02h pos %0d len %02h last %0b",
                   want.head, want.value, want.position, want.length, want.last);
          $display("  actual   head %02h byte %02h pos %0d len %02h last %0b",
                   got.head, got.value, got.position, got.length, got.last);
        end
        fail_count_o++;
      end
    end
  endtask

  // Everything is sampled at the rising edge, in channel order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_high     = 8'h00;
      addr_low      = 8'h00;
      acked_head    = AckedHeadReset;
      open_pos      = 0;
      open_head     = 8'h00;
      last_id       = 16'h0000;
      offer_modeled = 1'b0;
      owed_bytes.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgOwnAddrHigh: addr_high = cfg_data_i;
          CfgOwnAddrLow:  addr_low = cfg_data_i;
          CfgAckedHead:   acked_head = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && !offer_modeled) begin
        decode_line_byte(s_axis_tdata);
        offer_modeled = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) offer_modeled = 1'b0;
      if (m_axis_tvalid && m_axis_tready) check_decoded_byte();
    end
    pending_o = owed_bytes.size();
  end

endmodule

FILE: bench/tb_sextet_frame_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sextet_frame_receiver
// Drives line bytes and configuration writes into the sextet frame receiver
// and gives the verdict. A short directed sequence covers stray sextets and
// tails, a replaced head, broadcast and duplicate handling and short frames;
// four random phases with different register settings follow, mostly with
// well-formed frames and some aborted, short and noisy traffic. Both channels
// stall at random. Checking is done by sfr_checker.
// ----------------------------------------------------------------------------
module tb_sextet_frame_receiver;
  import sfr_pkg::*;

  localparam int unsigned SextetCapacity = 64;
  localparam int unsigned GapMax         = 6;
  localparam int unsigned PhaseBytes     = 80;
  localparam int unsigned Phases         = 4;
  localparam int unsigned SettleCycles   = 64;
  localparam int unsigned DrainCycles    = 200;
  // Register index past the end of the register list; writes are ignored.
  localparam logic [CfgIndexW-1:0] CfgSpare = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;    // [7:0] rx_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [23:0]          m_axis_tdata;    // [7:0] decoded_byte, [13:8] byte_position,
                                         // [21:14] declared_length
  logic [7:0]           m_axis_tuser;    // [7:0] frame_head
  logic                 m_axis_tlast;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [7:0]           cfg_data_i;

  int unsigned fail_count;
  int unsigned pending_bytes;
  int unsigned frames_kept;
  int unsigned bytes_compared;

  // Stimulus bookkeeping.
  logic        src_calm;
  logic        sink_calm;
  int unsigned line_bytes_sent;
  int unsigned noise_bytes;
  int unsigned settings_used;
  logic [7:0]  own_high;
  logic [7:0]  own_low;
  logic [7:0]  acked_head;
  logic [15:0] recent_id;
  logic [7:0]  payload [0:44];

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sextet_frame_receiver #(
    .SEXTET_CAPACITY(SextetCapacity)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  sfr_checker #(
    .CAPACITY(SextetCapacity)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_bytes),
    .frames_o     (frames_kept),
    .bytes_o      (bytes_compared)
  );

  // Offer one line byte after a random gap and wait for its transaction.
  // Called and returns at a falling edge.
  task automatic send_line_byte(input logic [7:0] b);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, GapMax);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= b;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    line_bytes_sent++;
  endtask

  // Send a head, the payload packed four sextets per three bytes, some spare
  // sextets that do not make a whole group, and the tail.
  task automatic send_frame(input logic [7:0] head, input int unsigned ngroups,
                            input int unsigned spare, input logic [7:0] tail);
    logic [23:0] word;
    logic [31:0] rnd;
    int unsigned g;
    send_line_byte(head);
    for (g = 0; g < ngroups; g++) begin
      word = {payload[3 * g], payload[3 * g + 1], payload[3 * g + 2]};
      send_line_byte({2'b00, word[23:18]});
      send_line_byte({2'b00, word[17:12]});
      send_line_byte({2'b00, word[11:6]});
      send_line_byte({2'b00, word[5:0]});
    end
    repeat (spare) begin
      rnd = $urandom;
      send_line_byte({2'b00, rnd[5:0]});
    end
    send_line_byte(tail);
  endtask

  // Random payload, mostly addressed to this node or broadcast, with
  // repeated and zero command ids on acknowledged heads.
  task automatic build_payload(input logic [7:0] head, input int unsigned ngroups);
    logic [31:0] rnd;
    int unsigned k;
    int unsigned pick;
    for (k = 0; k < 3 * ngroups; k++) begin
      rnd = $urandom;
      payload[k] = rnd[7:0];
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      payload[4] = own_high;
      payload[5] = own_low;
    end else if (pick < 85) begin
      payload[4] = 8'h00;
      payload[5] = 8'h00;
    end
    if (head == acked_head) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) {payload[0], payload[1]} = recent_id;
      else if (pick < 45) {payload[0], payload[1]} = 16'h0000;
      recent_id = {payload[0], payload[1]};
    end
  endtask

  function automatic logic [7:0] random_tail();
    logic [31:0] rnd;
    rnd = $urandom;
    return {2'b01, rnd[5:0]};
  endfunction

  // One random scenario on the line.
  task automatic random_traffic();
    logic [31:0] rnd;
    logic [7:0]  head;
    int unsigned pick;
    int unsigned ngroups;
    int unsigned n;
    pick     = $urandom_range(0, 99);
    rnd      = $urandom;
    head     = ($urandom_range(0, 9) < 4) ? acked_head : {1'b1, rnd[6:0]};
    src_calm = ($urandom_range(0, 3) == 0);
    if (pick < 60) begin
      ngroups = $urandom_range(2, 6);
      build_payload(head, ngroups);
      send_frame(head, ngroups, $urandom_range(0, 3), random_tail());
    end else if (pick < 70) begin
      // Long frames up to the full store.
      ngroups = $urandom_range(12, 15);
      build_payload(head, ngroups);
      send_frame(head, ngroups, $urandom_range(0, 3), random_tail());
    end else if (pick < 77) begin
      // Overfill the store: the extra sextet aborts the frame, so the
      // stragglers and the tail that follow are ignored.
      send_line_byte(head);
      repeat (SextetCapacity + $urandom_range(0, 2)) begin
        rnd = $urandom;
        send_line_byte({2'b00, rnd[5:0]});
      end
      send_line_byte(random_tail());
    end else if (pick < 87) begin
      // Too short to decode six bytes.
      ngroups = $urandom_range(0, 1);
      build_payload(head, ngroups);
      send_frame(head, ngroups, $urandom_range(0, 3), random_tail());
    end else if (pick < 93) begin
      // A frame cut off by a new head.
      send_line_byte({1'b1, rnd[14:8]});
      repeat ($urandom_range(0, 10)) begin
        rnd = $urandom;
        send_line_byte({2'b00, rnd[5:0]});
      end
      ngroups = $urandom_range(2, 6);
      build_payload(head, ngroups);
      send_frame(head, ngroups, $urandom_range(0, 3), random_tail());
    end else begin
      // Line noise outside any frame structure.
      n = $urandom_range(1, 6);
      repeat (n) begin
        rnd = $urandom;
        send_line_byte(rnd[7:0]);
      end
      noise_bytes += n;
    end
  endtask

  // Write one register, then leave the channel idle.
  task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [7:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stop sending until every owed byte has left, then let a dropped frame
  // finish its header pass.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [7:0] high, input logic [7:0] low,
                                input logic [7:0] acked);
    settle();
    cfg_write(CfgOwnAddrHigh, high);
    cfg_write(CfgOwnAddrLow, low);
    cfg_write(CfgAckedHead, acked);
    own_high   = high;
    own_low    = low;
    acked_head = acked;
    settings_used++;
  endtask

  // Result side: a random stall before each decoded byte, with calm runs.
  initial begin : result_sink
    int unsigned gap;
    m_axis_tready = 1'b0;
    sink_calm     = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      gap = sink_calm ? 0 : $urandom_range(0, GapMax);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Line side and verdict.
  initial begin : line_source
    logic [31:0] rnd;
    logic [7:0]  head;
    int unsigned phase;
    int unsigned phase_start;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'h00;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CfgOwnAddrHigh;
    cfg_data_i      = 8'h00;
    rst_ni          = 1'b0;
    src_calm        = 1'b0;
    line_bytes_sent = 0;
    noise_bytes     = 0;
    settings_used   = 1;
    own_high        = 8'h00;
    own_low         = 8'h00;
    acked_head      = AckedHeadReset;
    recent_id       = 16'h0000;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, with the register reset values.
    // Sextets and a tail with no open frame.
    send_line_byte(8'h00);
    send_line_byte(8'h3F);
    send_line_byte(8'h7F);
    // A head replaced by the acknowledged head, broadcast, six bytes.
    send_line_byte(8'hFF);
    {payload[0], payload[1], payload[2]} = 24'h1234FF;
    {payload[3], payload[4], payload[5]} = 24'h000000;
    send_frame(AckedHeadReset, 2, 0, 8'h40);
    recent_id = 16'h1234;
    // The same command again is a duplicate.
    send_frame(AckedHeadReset, 2, 0, 8'h40);
    // Empty frame and a one-group frame are both too short.
    send_frame(8'h80, 0, 0, 8'h7F);
    {payload[0], payload[1], payload[2]} = 24'hA5C33C;
    send_frame(8'hC5, 1, 2, 8'h55);

    // Random phases, each under its own register setting.
    for (phase = 0; phase < Phases; phase++) begin
      rnd = $urandom;
      case (phase)
        0: begin
          apply_settings(8'hFF, 8'hFF, 8'hFF);
          cfg_write(CfgSpare, 8'hA5);
        end
        1: apply_settings(rnd[7:0], rnd[15:8], 8'h80);
        2: apply_settings(8'h00, 8'h00, {1'b1, rnd[6:0]});
        default: apply_settings(rnd[7:0], rnd[15:8], AckedHeadReset);
      endcase
      phase_start = line_bytes_sent - noise_bytes;
      // A frame filling the store exactly yields the longest output.
      if (phase % 2 == 1) begin
        head = {1'b1, rnd[22:16]};
        build_payload(head, 15);
        send_frame(head, 15, 3, random_tail());
      end
      while (line_bytes_sent - noise_bytes - phase_start < PhaseBytes) random_traffic();
    end

    // Drain and give the verdict.
    s_axis_tvalid <= 1'b0;
    while (pending_bytes != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    $display("Sent %0d line bytes (%0d of them noise) under %0d register settings.",
             line_bytes_sent, noise_bytes, settings_used);
    $display("Compared %0d decoded bytes from %0d accepted frames.",
             bytes_compared, frames_kept);
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("PASS sextet_frame_receiver");
    end else begin
      $display("FAIL sextet_frame_receiver");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #20_000_000;
    $display("Timed out with %0d decoded bytes still owed.", pending_bytes);
    $display("FAIL sextet_frame_receiver");
    $finish;
  end

endmodule
